FILE: hw/rtl/time_window_max_average_top_defines.svh
// Assertion macros for the time window max/average block.
`ifndef TIME_WINDOW_MAX_AVERAGE_TOP_DEFINES_SVH
`define TIME_WINDOW_MAX_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTH
`define TWMA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
`define TWMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence violated");
`else
`define TWMA_ASSERT_ALWAYS(lbl, expr)
`define TWMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/twma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twma_pkg;

  // Ring depth must stay a power of two: slot indexes wrap by width.
  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_W     = 32;
  localparam int METRIC_W   = 16;
  localparam int SUM_W      = METRIC_W + CNT_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int ENTRY_W    = TIME_W + METRIC_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(1000);

  // Register index (paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  // Action codes
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EV_RD  = 5'b00010,
    S_EV_CHK = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DIV    = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/twma_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module twma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/time_window_max_average_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Update: the sample is written on accept, then S_EV_RD/S_EV_CHK run per evicted sample
//   plus a final check; all ring reads go through one RAM read port.
// Query: S_SCAN reads the held samples (one sample read per cycle), then S_DIV runs a
//   bit-serial division for SUM_W (23) quotient bits; out_valid pulses one cycle.
// busy is high for the whole transaction; the result is never stalled.
// rst_n (synchronous) empties the ring and sets window_length to 1000.
`include "time_window_max_average_top_defines.svh"

module time_window_max_average_top import twma_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_action,
  input  wire logic [TIME_W-1:0]     in_time_tick,
  input  wire logic [METRIC_W-1:0]   in_metric_value,
  output logic                       out_valid,
  output logic [METRIC_W-1:0]        out_window_maximum,
  output logic [METRIC_W-1:0]        out_window_average,
  output logic [CNT_W-1:0]           out_window_count,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [TIME_W-1:0]     win_r;
  logic [TIME_W-1:0]     t_r, t_nxt;
  logic [TIME_W-1:0]     low_r, low_nxt;
  logic [CNT_W-1:0]      issue_r, issue_nxt;
  logic                  pend_r, pend_nxt;
  logic [METRIC_W-1:0]   max_r, max_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W:0]        rem_r, rem_nxt;
  logic [SUM_W-1:0]      quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [METRIC_W-1:0]   out_max_r, out_max_nxt;
  logic [METRIC_W-1:0]   out_avg_r, out_avg_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic                  accept;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]     rd_time;
  logic [METRIC_W-1:0]   rd_metric;
  logic                  in_win;
  logic [CNT_W:0]        rem_shift;
  logic                  cfg_wr;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign rd_time   = ram_rdata[ENTRY_W-1 -: TIME_W];
  assign rd_metric = ram_rdata[METRIC_W-1:0];
  assign in_win    = (rd_time >= low_r) && (rd_time <= t_r);
  assign rem_shift = {rem_r[CNT_W-1:0], quot_r[SUM_W-1]};

  // Write slot: overwrite the oldest when full, else append after the newest
  assign ram_we    = accept && (in_action == ACT_UPDATE);
  assign ram_waddr = (occ_r == CNT_W'(DEPTH)) ? oldest_r
                                              : oldest_r + occ_r[IDX_W-1:0];

  twma_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_time_tick, in_metric_value}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    occ_nxt       = occ_r;
    t_nxt         = t_r;
    low_nxt       = low_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    out_max_nxt   = out_max_r;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    ram_raddr     = oldest_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          t_nxt = in_time_tick;
          if (in_action == ACT_UPDATE) begin
            if (occ_r == CNT_W'(DEPTH)) begin
              oldest_nxt = oldest_r + IDX_W'(1);
            end else begin
              occ_nxt = occ_r + CNT_W'(1);
            end
            state_nxt = S_EV_RD;
          end else begin
            low_nxt   = (in_time_tick >= win_r) ? in_time_tick - win_r : '0;
            issue_nxt = '0;
            pend_nxt  = 1'b0;
            max_nxt   = '0;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_EV_RD: begin
        // newest sample always stays
        state_nxt = (occ_r > CNT_W'(1)) ? S_EV_CHK : S_IDLE;
      end
      S_EV_CHK: begin
        if ((t_r - rd_time) >= win_r) begin
          oldest_nxt = oldest_r + IDX_W'(1);
          occ_nxt    = occ_r - CNT_W'(1);
          state_nxt  = S_EV_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        ram_raddr = oldest_r + issue_r[IDX_W-1:0];
        if (issue_r < occ_r) begin
          issue_nxt = issue_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && in_win) begin
          sum_nxt = sum_r + SUM_W'(rd_metric);
          cnt_nxt = cnt_r + CNT_W'(1);
          if (rd_metric > max_r) begin
            max_nxt = rd_metric;
          end
        end
        if (!pend_r && (issue_r == occ_r)) begin
          rem_nxt     = '0;
          quot_nxt    = sum_r;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_shift >= {1'b0, cnt_r}) begin
          rem_nxt  = rem_shift - {1'b0, cnt_r};
          quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_shift;
          quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = max_r;
          out_avg_nxt   = (cnt_r == '0) ? '0 : quot_nxt[METRIC_W-1:0];
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    low_r     <= low_nxt;
    issue_r   <= issue_nxt;
    max_r     <= max_nxt;
    sum_r     <= sum_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quot_r    <= quot_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_max_r <= out_max_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW) ? APB_DATA_W'(win_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else if (cfg_wr && (paddr[2] == REG_WINDOW)) begin
      win_r <= pwdata[TIME_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_window_maximum = out_max_r;
  assign out_window_average = out_avg_r;
  assign out_window_count   = out_cnt_r;

  `TWMA_ASSERT_ALWAYS(a_occ_bound, occ_r <= CNT_W'(DEPTH))
  `TWMA_ASSERT_NEXT(a_upd_keeps_one, accept && (in_action == ACT_UPDATE), occ_r != '0)
  `TWMA_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `TWMA_ASSERT_NEXT(a_result_from_div, state_r != S_DIV, !out_valid)
  `TWMA_ASSERT_ALWAYS(a_count_bound, !out_valid || (out_window_count <= CNT_W'(DEPTH)))

endmodule

`default_nettype wire

FILE: tb/tb_time_window_max_average_top.sv
`timescale 1ns / 1ps

module tb_time_window_max_average_top;
  import twma_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

  typedef struct {
    logic                act;
    logic [TIME_W-1:0]   tick;
    logic [METRIC_W-1:0] metric;
  } sample_cmd_t;

  typedef struct packed {
    logic [METRIC_W-1:0] peak;
    logic [METRIC_W-1:0] mean;
    logic [CNT_W-1:0]    hits;
  } window_stats_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_action = ACT_UPDATE;
  logic [TIME_W-1:0]     in_time_tick = '0;
  logic [METRIC_W-1:0]   in_metric_value = '0;
  logic                  out_valid;
  logic [METRIC_W-1:0]   out_window_maximum;
  logic [METRIC_W-1:0]   out_window_average;
  logic [CNT_W-1:0]      out_window_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  time_window_max_average_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_time_tick       (in_time_tick),
    .in_metric_value    (in_metric_value),
    .out_valid          (out_valid),
    .out_window_maximum (out_window_maximum),
    .out_window_average (out_window_average),
    .out_window_count   (out_window_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk = ~clk;

  // Shadow of the sample ring and the window register
  logic [TIME_W-1:0]   ring_tick [DEPTH];
  logic [METRIC_W-1:0] ring_metric [DEPTH];
  logic [IDX_W-1:0]    ring_head = '0;
  int                  ring_fill = 0;
  logic [TIME_W-1:0]   win_len = WINDOW_RESET;

  sample_cmd_t   cmd_backlog[$];
  window_stats_t stats_due[$];
  logic [TIME_W-1:0] cur_tick = '0;
  int  idle_pct = 0;
  int  gap_left = 0;
  logic in_taken = 1'b0;
  sample_cmd_t drv_cmd;

  int err_cnt = 0;
  int n_updates = 0;
  int n_queries = 0;
  int n_writes = 0;
  int n_evicted = 0;
  int n_overwrites = 0;
  int peak_hits = 0;

  function automatic void ring_append(logic [TIME_W-1:0] t, logic [METRIC_W-1:0] m);
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] age;
    if (ring_fill >= DEPTH) begin
      slot = ring_head;
      ring_head++;
      n_overwrites++;
    end else begin
      slot = ring_head + IDX_W'(ring_fill);
      ring_fill++;
    end
    ring_tick[slot] = t;
    ring_metric[slot] = m;
    // age wraps modulo 2^TIME_W, like the hardware subtractor
    age = t - ring_tick[ring_head];
    while (ring_fill > 1 && age >= win_len) begin
      ring_head++;
      ring_fill--;
      n_evicted++;
      age = t - ring_tick[ring_head];
    end
  endfunction

  function automatic window_stats_t window_scan(logic [TIME_W-1:0] t);
    window_stats_t     s;
    logic [TIME_W-1:0] lo;
    logic [IDX_W-1:0]  slot;
    int unsigned       total;
    int unsigned       hits;
    s = '0;
    total = 0;
    hits = 0;
    lo = (t >= win_len) ? t - win_len : '0;
    for (int i = 0; i < ring_fill; i++) begin
      slot = ring_head + IDX_W'(i);
      if (ring_tick[slot] >= lo && ring_tick[slot] <= t) begin
        total += 32'(ring_metric[slot]);
        hits++;
        if (ring_metric[slot] > s.peak) s.peak = ring_metric[slot];
      end
    end
    if (hits != 0) s.mean = METRIC_W'(total / hits);
    s.hits = CNT_W'(hits);
    return s;
  endfunction

  // Driver: hold a transaction until accepted, then insert an optional gap
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (cmd_backlog.size() != 0) begin
      drv_cmd = cmd_backlog[0];
      cmd_backlog.delete(0);
      in_action <= drv_cmd.act;
      in_time_tick <= drv_cmd.tick;
      in_metric_value <= drv_cmd.metric;
      start <= 1'b1;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        gap_left <= $urandom_range(1, 3);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results, advance the shadow ring, track register traffic
  always @(posedge clk) begin
    window_stats_t due;
    in_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (stats_due.size() == 0) begin
          err_cnt++;
          $error("result with none expected: window_maximum %0d window_average %0d",
                 out_window_maximum, out_window_average);
        end else begin
          due = stats_due[0];
          stats_due.delete(0);
          n_queries++;
          if (out_window_maximum !== due.peak) begin
            err_cnt++;
            $error("window_maximum expected %0d actual %0d", due.peak, out_window_maximum);
          end
          if (out_window_average !== due.mean) begin
            err_cnt++;
            $error("window_average expected %0d actual %0d", due.mean, out_window_average);
          end
          if (out_window_count !== due.hits) begin
            err_cnt++;
            $error("window_count expected %0d actual %0d", due.hits, out_window_count);
          end
        end
      end
      if (start && !busy) begin
        if (in_action == ACT_QUERY) begin
          due = window_scan(in_time_tick);
          if (int'(due.hits) > peak_hits) peak_hits = int'(due.hits);
          stats_due.insert(stats_due.size(), due);
        end else begin
          n_updates++;
          ring_append(in_time_tick, in_metric_value);
        end
      end
      if (psel && penable && pready && paddr == WINDOW_ADDR) begin
        if (pwrite) begin
          win_len = pwdata[TIME_W-1:0];
          n_writes++;
        end else if (prdata[TIME_W-1:0] !== win_len) begin
          err_cnt++;
          $error("window_length expected %0d actual %0d", win_len, prdata);
        end
      end
    end
  end

  function automatic void push_cmd(logic act, logic [TIME_W-1:0] t, logic [METRIC_W-1:0] m);
    sample_cmd_t c;
    c.act = act;
    c.tick = t;
    c.metric = m;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  function automatic void queue_phase(int count, int unsigned step_max, int gap_pct);
    logic [TIME_W-1:0]   t;
    logic [METRIC_W-1:0] m;
    int                  pick;
    idle_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      m = METRIC_W'($urandom);
      if ($urandom_range(0, 99) < 55) begin
        // mostly advancing timestamps, a few stepping back
        if ($urandom_range(0, 99) < 3) t = cur_tick - TIME_W'($urandom_range(1, 5000));
        else t = cur_tick + TIME_W'($urandom_range(0, step_max));
        cur_tick = t;
        pick = $urandom_range(0, 9);
        if (pick == 0) m = '0;
        else if (pick == 1) m = '1;
        push_cmd(ACT_UPDATE, t, m);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) t = cur_tick + TIME_W'($urandom_range(0, 2 * step_max + 2));
        else if (pick < 93) t = cur_tick - TIME_W'($urandom_range(0, 4 * step_max + 4));
        else t = TIME_W'($urandom);
        push_cmd(ACT_QUERY, t, m);
      end
    end
  endfunction

  task automatic drain_block();
    while (cmd_backlog.size() != 0) @(negedge clk);
    @(negedge clk);
    while (start || stats_due.size() != 0) @(negedge clk);
    // updates give no result: let a last eviction run out
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [TIME_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= WINDOW_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    // read back in the next transaction
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] w;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty window, extremes, equal times, wrap of the time difference
    push_cmd(ACT_QUERY, '0, '0);
    push_cmd(ACT_UPDATE, 5, '1);
    push_cmd(ACT_QUERY, 3, '0);
    push_cmd(ACT_QUERY, 5, '1);
    push_cmd(ACT_UPDATE, 5, '0);
    push_cmd(ACT_QUERY, 1005, '0);
    push_cmd(ACT_UPDATE, 1005, 16'd1);
    push_cmd(ACT_QUERY, 1005, '0);
    push_cmd(ACT_QUERY, '1, '1);
    push_cmd(ACT_UPDATE, '1, 16'h8000);
    push_cmd(ACT_QUERY, '1, '0);
    push_cmd(ACT_UPDATE, 10, 16'd7);
    push_cmd(ACT_QUERY, 10, '0);
    push_cmd(ACT_QUERY, 999, '0);
    push_cmd(ACT_UPDATE, 0, 16'h1234);
    push_cmd(ACT_QUERY, 0, '0);
    push_cmd(ACT_UPDATE, 2000, 16'hAAAA);
    push_cmd(ACT_UPDATE, 2000, 16'h5555);
    push_cmd(ACT_UPDATE, 2000, '1);
    push_cmd(ACT_QUERY, 2000, '0);
    push_cmd(ACT_QUERY, 2999, '0);
    push_cmd(ACT_QUERY, 3000, '0);
    push_cmd(ACT_QUERY, 3001, '0);
    cur_tick = 2000;
    idle_pct = 30;
    drain_block();

    queue_phase(150, 30, 30);
    drain_block();

    cfg_write('0);
    queue_phase(200, 3, 0);
    drain_block();

    // widest window: ring fills and overwrites, timestamps wrap
    cfg_write('1);
    cur_tick = 32'hFF00_0000 + TIME_W'($urandom_range(0, 32'h00FF_FFFF));
    queue_phase(250, 1_000_000, 40);
    drain_block();

    cfg_write(50);
    queue_phase(250, 10, 30);
    drain_block();

    w = TIME_W'($urandom);
    cfg_write(w);
    cur_tick = TIME_W'($urandom);
    queue_phase(250, (w >> 6) + 1, 25);
    drain_block();

    cfg_write(1);
    queue_phase(200, 2, 35);
    drain_block();

    cfg_write(TIME_W'($urandom_range(100, 5000)));
    queue_phase(100, 40, 30);
    drain_block();
    queue_phase(300, 40, 0);
    drain_block();

    $display("Covered %0d updates (%0d evictions, %0d full-ring overwrites), %0d queries,",
             n_updates, n_evicted, n_overwrites, n_queries);
    $display("%0d window settings written; largest window count seen %0d",
             n_writes, peak_hits);
    if (err_cnt == 0 && stats_due.size() == 0) begin
      $display("PASS time_window_max_average_top");
    end else begin
      $display("FAIL time_window_max_average_top");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAIL time_window_max_average_top");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/twma_pkg.sv
hw/rtl/twma_ram.sv
hw/rtl/time_window_max_average_top.sv
tb/tb_time_window_max_average_top.sv
